@@ rtl/core/sacache_pkg.sv @@
// Shared types and constants for the set-associative cache tag store.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package sacache_pkg;

    localparam int SET_INDEX_W = 6;
    localparam int TAG_IN_W    = 24;
    localparam int KIND_W      = 2;
    localparam int WAY_OUT_W   = 3;
    localparam int CFG_W       = 4;
    localparam int WIDE_W      = 48;

    localparam logic [CFG_W-1:0]  WAYS_IN_USE_RESET = 4'd8;

    localparam logic [KIND_W-1:0] KIND_HIT        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MISS_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MISS_OCC   = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic read;
        logic lookup;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/sacache_ctrl.sv @@
// Controller state machine: reset clearing sweep, row read, lookup/write-back.
// Depends on sacache_pkg for the command and status structs.
`default_nettype none

module sacache_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  sacache_pkg::status_t  status,
    output sacache_pkg::cmd_t     cmd,
    output logic                  busy
);
    import sacache_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef SYNTHESIS
    a_lookup_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |=> cmd.lookup)
        else $error("lookup did not follow row read");
    a_no_read_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear && (cmd.read || cmd.lookup)))
        else $error("item taken during clearing sweep");
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |-> busy)
        else $error("lookup while not busy");
    a_no_back_to_back_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |=> !cmd.read)
        else $error("second read before write-back");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sacache_dp.sv @@
// Datapath: set memory (valid, age, tag per way), hit/victim selection,
// recency update, config register and result registers. Uses sacache_pkg.
`default_nettype none

module sacache_dp #(
    parameter int SETS     = 64,
    parameter int WAYS     = 8,
    parameter int TAG_BITS = 24
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  sacache_pkg::cmd_t                        cmd,
    output sacache_pkg::status_t                     status,
    input  wire [sacache_pkg::SET_INDEX_W-1:0]       set_index,
    input  wire [sacache_pkg::TAG_IN_W-1:0]          tag,
    input  wire                                      cfg_we,
    input  wire [sacache_pkg::CFG_W-1:0]             cfg_data,
    output logic                                     done,
    output logic [sacache_pkg::KIND_W-1:0]           result_kind,
    output logic [sacache_pkg::WAY_OUT_W-1:0]        way,
    output logic                                     evicted_valid,
    output logic [sacache_pkg::TAG_IN_W-1:0]         evicted_tag
);
    import sacache_pkg::*;

    localparam int SET_BITS   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AGE_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_BITS = 1 + AGE_BITS + TAG_BITS;
    localparam int ROW_BITS   = WAYS * ENTRY_BITS;
    localparam int IN_SETS    = 2 ** SET_INDEX_W;
    localparam int NW_BITS    = $clog2(WAYS + 1) + 1;

    localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(WAYS - 1);

    // Constant table: input index reduced modulo SETS
    logic [SET_BITS-1:0] mod_tbl [IN_SETS];
    for (genvar g = 0; g < IN_SETS; g++)
    begin : g_mod
        assign mod_tbl[g] = SET_BITS'(g % SETS);
    end

    logic [ROW_BITS-1:0] mem [SETS];
    logic [ROW_BITS-1:0] row_reg;
    logic [SET_BITS-1:0] set_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [SET_BITS-1:0] clr_cnt_reg;
    logic [CFG_W-1:0]    ways_reg;

    logic [KIND_W-1:0]    kind_reg;
    logic [WAY_OUT_W-1:0] way_reg;
    logic                 ev_valid_reg;
    logic [TAG_IN_W-1:0]  ev_tag_reg;
    logic                 done_reg;

    logic [WIDE_W-1:0]    tag_wide;
    logic [TAG_BITS-1:0]  tag_in;

    logic                 v     [WAYS];
    logic [AGE_BITS-1:0]  a     [WAYS];
    logic [TAG_BITS-1:0]  tg    [WAYS];
    logic [WAYS-1:0]      in_use;
    logic [NW_BITS-1:0]   n_eff;

    logic                 hit;
    logic                 found_inv;
    logic                 any_valid;
    logic [WAY_BITS-1:0]  hit_way;
    logic [WAY_BITS-1:0]  inv_way;
    logic [WAY_BITS-1:0]  old_way;
    logic [AGE_BITS-1:0]  old_age;
    logic [WAY_BITS-1:0]  w_sel;
    logic                 was_valid;
    logic [AGE_BITS-1:0]  sel_age;
    logic [ROW_BITS-1:0]  new_row;
    logic [AGE_BITS-1:0]  age_new;
    logic [KIND_W-1:0]    kind_c;
    logic                 ev_valid_c;
    logic [TAG_IN_W-1:0]  ev_tag_c;
    logic [WIDE_W-1:0]    ev_wide;
    logic [7:0]           way_wide;

    logic                 wr_en;
    logic [SET_BITS-1:0]  wr_addr;
    logic [ROW_BITS-1:0]  wr_data;

    assign tag_wide = WIDE_W'(tag);
    assign tag_in   = tag_wide[TAG_BITS-1:0];

    // Clamp ways in use to 1..WAYS
    always_comb
    begin
        if (ways_reg == '0)
        begin
            n_eff = NW_BITS'(1);
        end
        else if (NW_BITS'(ways_reg) > NW_BITS'(WAYS))
        begin
            n_eff = NW_BITS'(WAYS);
        end
        else
        begin
            n_eff = NW_BITS'(ways_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            v[i]      = row_reg[i*ENTRY_BITS + AGE_BITS + TAG_BITS];
            a[i]      = row_reg[i*ENTRY_BITS + TAG_BITS +: AGE_BITS];
            tg[i]     = row_reg[i*ENTRY_BITS +: TAG_BITS];
            in_use[i] = (NW_BITS'(i) < n_eff);
        end
    end

    // Hit, first invalid way, and oldest way; lowest index wins ties
    always_comb
    begin
        hit       = 1'b0;
        found_inv = 1'b0;
        any_valid = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        old_way   = '0;
        old_age   = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (in_use[i] && v[i] && (tg[i] == tag_reg))
            begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(i);
            end
            if (in_use[i] && !v[i])
            begin
                found_inv = 1'b1;
                inv_way   = WAY_BITS'(i);
            end
            if (in_use[i] && v[i])
            begin
                any_valid = 1'b1;
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            if (in_use[i] && ((i == 0) || (a[i] > old_age)))
            begin
                old_age = a[i];
                old_way = WAY_BITS'(i);
            end
        end
    end

    always_comb
    begin
        if (hit)
        begin
            w_sel = hit_way;
        end
        else if (found_inv)
        begin
            w_sel = inv_way;
        end
        else
        begin
            w_sel = old_way;
        end
    end

    assign was_valid = v[w_sel];
    assign sel_age   = a[w_sel];

    // Promote selected way to most recent; age the ones it passes
    always_comb
    begin
        new_row = row_reg;
        age_new = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            age_new = a[i];
            if (WAY_BITS'(i) == w_sel)
            begin
                new_row[i*ENTRY_BITS +: ENTRY_BITS] = {1'b1, {AGE_BITS{1'b0}}, tag_reg};
            end
            else
            begin
                if (v[i] && (!was_valid || (a[i] < sel_age)) && (a[i] < AGE_MAX))
                begin
                    age_new = a[i] + AGE_BITS'(1);
                end
                new_row[i*ENTRY_BITS + TAG_BITS +: AGE_BITS] = age_new;
            end
        end
    end

    assign ev_wide    = WIDE_W'(tg[w_sel]);
    assign ev_valid_c = !hit && !found_inv;
    assign ev_tag_c   = ev_valid_c ? ev_wide[TAG_IN_W-1:0] : '0;
    assign way_wide   = 8'(w_sel);

    always_comb
    begin
        if (hit)
        begin
            kind_c = KIND_HIT;
        end
        else if (any_valid)
        begin
            kind_c = KIND_MISS_OCC;
        end
        else
        begin
            kind_c = KIND_MISS_EMPTY;
        end
    end

    assign wr_en   = cmd.clear || cmd.lookup;
    assign wr_addr = cmd.clear ? clr_cnt_reg : set_reg;
    assign wr_data = cmd.clear ? '0 : new_row;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.read)
        begin
            row_reg <= mem[mod_tbl[set_index]];
            set_reg <= mod_tbl[set_index];
            tag_reg <= tag_in;
        end
        if (cmd.lookup)
        begin
            kind_reg     <= kind_c;
            way_reg      <= way_wide[WAY_OUT_W-1:0];
            ev_valid_reg <= ev_valid_c;
            ev_tag_reg   <= ev_tag_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            ways_reg    <= WAYS_IN_USE_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.lookup;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_BITS'(1);
            end
            if (cfg_we)
            begin
                ways_reg <= cfg_data;
            end
        end
    end

    assign status.clear_last = (clr_cnt_reg == SET_BITS'(SETS - 1));

    assign done          = done_reg;
    assign result_kind   = kind_reg;
    assign way           = way_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_tag   = ev_tag_reg;

endmodule

`default_nettype wire

@@ rtl/core/set_assoc_cache_tag_lru_top.sv @@
// Result strobe (done) is registered: idle takes start with the row read of the set memory,
// then the look state does the lookup and write-back; no new start is taken before that.
// After reset, busy stays high while the set memory is swept clear.
// Results show for one cycle on done; the receiver cannot stall. Config writes never wait.
// Top level of the tag store; instantiates sacache_ctrl and sacache_dp, uses sacache_pkg.
`default_nettype none

module set_assoc_cache_tag_lru_top #(
    parameter int SETS     = 64,
    parameter int WAYS     = 8,
    parameter int TAG_BITS = 24
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire [sacache_pkg::SET_INDEX_W-1:0]   set_index,
    input  wire [sacache_pkg::TAG_IN_W-1:0]      tag,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [sacache_pkg::CFG_W-1:0]         cfg_data,
    output logic                                 done,
    output logic [sacache_pkg::KIND_W-1:0]       result_kind,
    output logic [sacache_pkg::WAY_OUT_W-1:0]    way,
    output logic                                 evicted_valid,
    output logic [sacache_pkg::TAG_IN_W-1:0]     evicted_tag
);
    import sacache_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    sacache_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sacache_dp #(
        .SETS     (SETS),
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .set_index     (set_index),
        .tag           (tag),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .result_kind   (result_kind),
        .way           (way),
        .evicted_valid (evicted_valid),
        .evicted_tag   (evicted_tag)
    );

endmodule

`default_nettype wire
